/* hdl/pixel_sepia_anaglyph_writer_core_assert.svh */
// Assertion macros used by the checker of the pixel writer core.
// Each macro expects clk and arst_n in scope.
`ifndef PIXEL_SEPIA_ANAGLYPH_WRITER_CORE_ASSERT_SVH
`define PIXEL_SEPIA_ANAGLYPH_WRITER_CORE_ASSERT_SVH

// Same-cycle implication
`define PSAW_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psaw check failed");

// Next-cycle implication
`define PSAW_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psaw check failed");

`endif

/* hdl/psaw_pkg.sv */
package psaw_pkg;

	// Field widths
	localparam int COORD_BITS   = 12;
	localparam int FRAC_BITS    = 12;
	localparam int CHAN_BITS    = FRAC_BITS + 1;
	localparam int STRIDE_BITS  = 15;
	localparam int BPP_BITS     = 6;
	localparam int ADDR_BITS    = 27;
	localparam int BYTE_BITS    = 8;
	localparam int CFG_BITS     = 15;
	localparam int REG_IDX_BITS = 3;

	// Register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_SEPIA_ENABLE   = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_STEREO_ENABLE  = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_EYE_INDEX      = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_LINE_STRIDE    = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_BITS_PER_PIXEL = 3'd4;

	localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 15'd4096;
	localparam logic [BPP_BITS-1:0]    BPP_RESET    = 6'd32;

	// Sepia arithmetic: coefficients in thousandths
	localparam int K_BITS      = 10;
	localparam int SUM_BITS    = CHAN_BITS + 11;
	localparam int QUO_IN_BITS = FRAC_BITS + 10;
	localparam logic [SUM_BITS-1:0] SAT_LIMIT =
		SUM_BITS'(64'd1000 << FRAC_BITS);
	localparam logic [CHAN_BITS-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

	// floor(s / 1000) as (s * RECIP_MUL) >> RECIP_SHIFT, exact for s < 2^QUO_IN_BITS
	localparam int RECIP_SHIFT = QUO_IN_BITS + 10;
	localparam int RECIP_BITS  = FRAC_BITS + 11;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000;
	localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'(RECIP_FULL);
	localparam int PROD_BITS = QUO_IN_BITS + RECIP_BITS;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [CHAN_BITS-1:0]  red_in;
		logic [CHAN_BITS-1:0]  green_in;
		logic [CHAN_BITS-1:0]  blue_in;
	} pixel_in_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] byte_address;
		logic [BYTE_BITS-1:0] blue_byte;
		logic [BYTE_BITS-1:0] green_byte;
		logic [BYTE_BITS-1:0] red_byte;
	} pixel_out_t;

	// Stage load strobes from the pipeline control
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
	} adv_t;

	typedef struct packed {
		logic sepia_enable;
		logic stereo_enable;
		logic eye_index;
	} color_cfg_t;

endpackage

/* hdl/pixel_sepia_anaglyph_writer_core.sv */
// Channel | Handshake             | Payload
// px      | px_valid / px_stall   | px_data  (pixel_in_t: x, y, r, g, b)
// wr      | wr_valid / wr_stall   | wr_data  (pixel_out_t: address, b, g, r)
// cfg     | cfg_write             | cfg_index, cfg_data
//
// One pixel per clock sustained while the result is not stalled.
// Stages: input register, matrix sums and address, reciprocal divide, byte result.
// Each stage moves when the next one is empty or moving, so bubbles are squeezed out.
// A stalled result holds the pipe only once every stage is full.
// Reset clears the stage valid bits and sets the configuration registers to their defaults.
module pixel_sepia_anaglyph_writer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  px_valid,
	output logic                                  px_stall,
	input  psaw_pkg::pixel_in_t                   px_data,
	output logic                                  wr_valid,
	input  logic                                  wr_stall,
	output psaw_pkg::pixel_out_t                  wr_data,
	input  logic                                  cfg_write,
	input  logic [psaw_pkg::REG_IDX_BITS-1:0]     cfg_index,
	input  logic [psaw_pkg::CFG_BITS-1:0]         cfg_data
);

	localparam int AB  = psaw_pkg::ADDR_BITS;
	localparam int RTB = psaw_pkg::COORD_BITS + psaw_pkg::STRIDE_BITS;
	localparam int CTB = psaw_pkg::COORD_BITS + psaw_pkg::BPP_BITS - 3;

	logic                                 sepia_q;
	logic                                 stereo_q;
	logic                                 eye_q;
	logic [psaw_pkg::STRIDE_BITS-1:0]     stride_q;
	logic [psaw_pkg::BPP_BITS-1:0]        bpp_q;

	logic                v_s1, v_s2, v_s3, out_valid_q;
	logic                rdy1, rdy2, rdy3, rdy_out;
	psaw_pkg::adv_t      adv;
	psaw_pkg::color_cfg_t color_cfg;
	psaw_pkg::pixel_in_t px_s1;

	logic [RTB-1:0]      row_term;
	logic [CTB-1:0]      col_term;
	logic [AB-1:0]       addr_sum;
	logic [AB-1:0]       addr_s2, addr_s3, addr_q;

	logic [psaw_pkg::BYTE_BITS-1:0] red_b, green_b, blue_b;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sepia_q  <= 1'b0;
			stereo_q <= 1'b0;
			eye_q    <= 1'b0;
			stride_q <= psaw_pkg::STRIDE_RESET;
			bpp_q    <= psaw_pkg::BPP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				psaw_pkg::REG_SEPIA_ENABLE:   sepia_q  <= cfg_data[0];
				psaw_pkg::REG_STEREO_ENABLE:  stereo_q <= cfg_data[0];
				psaw_pkg::REG_EYE_INDEX:      eye_q    <= cfg_data[0];
				psaw_pkg::REG_LINE_STRIDE:    stride_q <= cfg_data[psaw_pkg::STRIDE_BITS-1:0];
				psaw_pkg::REG_BITS_PER_PIXEL: bpp_q    <= cfg_data[psaw_pkg::BPP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Ready chain, back from the result register
	assign rdy_out  = !out_valid_q || !wr_stall;
	assign rdy3     = !v_s3 || rdy_out;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign px_stall = !rdy1;

	assign adv.ld_s2  = v_s1 && rdy2;
	assign adv.ld_s3  = v_s2 && rdy3;
	assign adv.ld_out = v_s3 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1        <= px_valid;
			if (rdy2)    v_s2        <= v_s1;
			if (rdy3)    v_s3        <= v_s2;
			if (rdy_out) out_valid_q <= v_s3;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (px_valid && rdy1)
			px_s1 <= px_data;
	end

	// Address: y * stride + (bpp / 8) * x, wraps at the address width
	always_comb begin
		row_term = RTB'(px_s1.pixel_y) * RTB'(stride_q);
		col_term = CTB'(bpp_q[psaw_pkg::BPP_BITS-1:3]) * CTB'(px_s1.pixel_x);
		addr_sum = AB'(row_term) + AB'(col_term);
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s2)  addr_s2 <= addr_sum;
		if (adv.ld_s3)  addr_s3 <= addr_s2;
		if (adv.ld_out) addr_q  <= addr_s3;
	end

	assign color_cfg.sepia_enable  = sepia_q;
	assign color_cfg.stereo_enable = stereo_q;
	assign color_cfg.eye_index     = eye_q;

	psaw_color u_color (
		.clk        (clk),
		.adv        (adv),
		.cfg        (color_cfg),
		.red        (px_s1.red_in),
		.green      (px_s1.green_in),
		.blue       (px_s1.blue_in),
		.red_byte   (red_b),
		.green_byte (green_b),
		.blue_byte  (blue_b)
	);

	assign wr_valid             = out_valid_q;
	assign wr_data.byte_address = addr_q;
	assign wr_data.blue_byte    = blue_b;
	assign wr_data.green_byte   = green_b;
	assign wr_data.red_byte     = red_b;

endmodule

/* hdl/psaw_color.sv */
// Color path: sepia matrix (when enabled), clamp, divide by 1000, anaglyph mask (when enabled), byte scale.
module psaw_color (
	input  logic                               clk,
	input  psaw_pkg::adv_t                     adv,
	input  psaw_pkg::color_cfg_t               cfg,
	input  logic [psaw_pkg::CHAN_BITS-1:0]     red,
	input  logic [psaw_pkg::CHAN_BITS-1:0]     green,
	input  logic [psaw_pkg::CHAN_BITS-1:0]     blue,
	output logic [psaw_pkg::BYTE_BITS-1:0]     red_byte,
	output logic [psaw_pkg::BYTE_BITS-1:0]     green_byte,
	output logic [psaw_pkg::BYTE_BITS-1:0]     blue_byte
);

	localparam int CB = psaw_pkg::CHAN_BITS;
	localparam int SB = psaw_pkg::SUM_BITS;
	localparam int QB = psaw_pkg::QUO_IN_BITS;
	localparam int PB = psaw_pkg::PROD_BITS;
	localparam int VB = CB + psaw_pkg::BYTE_BITS - psaw_pkg::FRAC_BITS;

	function automatic logic [psaw_pkg::K_BITS-1:0] sepia_coef(input int row, input int col);
		logic [psaw_pkg::K_BITS-1:0] k;
		case (row * 3 + col)
			0: k = 10'd393;
			1: k = 10'd769;
			2: k = 10'd189;
			3: k = 10'd349;
			4: k = 10'd686;
			5: k = 10'd168;
			6: k = 10'd272;
			7: k = 10'd534;
			8: k = 10'd131;
			default: k = '0;
		endcase
		return k;
	endfunction

	// min(255, (c * 255) >> FRAC_BITS)
	function automatic logic [psaw_pkg::BYTE_BITS-1:0] to_byte(input logic [CB-1:0] c);
		logic [CB+7:0] scaled;
		logic [VB-1:0] v;
		scaled = {c, 8'b0} - {8'b0, c};
		v = scaled[CB+7:psaw_pkg::FRAC_BITS];
		if (v > VB'(255))
			return 8'hFF;
		return v[7:0];
	endfunction

	// index 0 red, 1 green, 2 blue
	logic [2:0][CB-1:0] chan_in;
	logic [2:0][SB-1:0] sum;
	logic [2:0]         sat;

	logic [2:0][CB-1:0] raw_s2;
	logic [2:0][QB-1:0] sum_s2;
	logic [2:0]         sat_s2;
	logic               sepia_s2;

	logic [2:0][PB-1:0] prod;
	logic [2:0][CB-1:0] chan_next;
	logic [2:0][CB-1:0] chan_s3;
	logic [2:0][CB-1:0] masked;

	assign chan_in = {blue, green, red};

	// Matrix rows: constant-coefficient dot products
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = SB'(sepia_coef(r, 0)) * SB'(chan_in[0])
			       + SB'(sepia_coef(r, 1)) * SB'(chan_in[1])
			       + SB'(sepia_coef(r, 2)) * SB'(chan_in[2]);
			sat[r] = sum[r] > psaw_pkg::SAT_LIMIT;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			raw_s2   <= chan_in;
			sepia_s2 <= cfg.sepia_enable;
			sat_s2   <= sat;
			for (int r = 0; r < 3; r++)
				sum_s2[r] <= sum[r][QB-1:0];
		end
	end

	// Divide by 1000 via reciprocal; unclamped sums stay below 2^QB
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			prod[r] = PB'(sum_s2[r]) * PB'(psaw_pkg::RECIP_MUL);
			if (!sepia_s2)
				chan_next[r] = raw_s2[r];
			else if (sat_s2[r])
				chan_next[r] = psaw_pkg::ONE_FX;
			else
				chan_next[r] = CB'(prod[r] >> psaw_pkg::RECIP_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s3)
			chan_s3 <= chan_next;
	end

	// Anaglyph: eye 0 drops red, eye 1 drops green
	always_comb begin
		masked = chan_s3;
		if (cfg.stereo_enable) begin
			if (!cfg.eye_index)
				masked[0] = '0;
			else
				masked[1] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_out) begin
			red_byte   <= to_byte(masked[0]);
			green_byte <= to_byte(masked[1]);
			blue_byte  <= to_byte(masked[2]);
		end
	end

endmodule

/* hdl/psaw_checker.sv */
`include "pixel_sepia_anaglyph_writer_core_assert.svh"

// Port-level checks for the pixel writer core
module psaw_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 px_valid,
	input logic                 px_stall,
	input logic                 wr_valid,
	input logic                 wr_stall,
	input psaw_pkg::pixel_out_t wr_data
);

	// A stalled result stays up
	`PSAW_ASSERT_NEXT(a_wr_hold, wr_valid && wr_stall, wr_valid)

	// A stalled result keeps its payload
	`PSAW_ASSERT_NEXT(a_wr_stable, wr_valid && wr_stall, $stable(wr_data))

	// Empty result register means the pipe can take a request
	`PSAW_ASSERT_IMPL(a_px_free, !wr_valid, !px_stall)

	// No back pressure: a request passes s1, s2, s3 to wr_valid
	`PSAW_ASSERT_NEXT(a_latency, px_valid && !px_stall && !wr_stall ##1 !wr_stall ##1 !wr_stall ##1 !wr_stall, wr_valid)

endmodule

bind pixel_sepia_anaglyph_writer_core psaw_checker u_psaw_checker (.*);
